// ===== src/decimal_number_literal_recognizer_top_assert.svh =====
// Assertion macros for the decimal number literal recognizer.
`ifndef DECIMAL_NUMBER_LITERAL_RECOGNIZER_TOP_ASSERT_SVH
`define DECIMAL_NUMBER_LITERAL_RECOGNIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DNLR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dnlr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DNLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dnlr assertion failed");

// Condition must hold at every clock edge.
`define DNLR_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("dnlr assertion failed");

`endif

// ===== src/dnlr_pkg.sv =====
// Shared types and character constants for the decimal number literal recognizer.
package dnlr_pkg;

   // Character codes that the grammar reacts to.
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_EXP_LO  = 8'h65;
   localparam logic [7:0] CHAR_EXP_UP  = 8'h45;

   // Position in the number grammar, one-hot.
   typedef enum logic [9:0] {
      PH_START    = 10'b00_0000_0001,
      PH_SIGN     = 10'b00_0000_0010,
      PH_INT      = 10'b00_0000_0100,
      PH_DOT_BARE = 10'b00_0000_1000,
      PH_DOT_INT  = 10'b00_0001_0000,
      PH_FRAC     = 10'b00_0010_0000,
      PH_EXP_MARK = 10'b00_0100_0000,
      PH_EXP_SIGN = 10'b00_1000_0000,
      PH_EXP_DIG  = 10'b01_0000_0000,
      PH_DEAD     = 10'b10_0000_0000
   } phase_type;

   // Verdict on the bytes seen so far.
   typedef struct packed {
      logic is_number;
      logic rejected;
   } verdict_type;

endpackage

// ===== src/dnlr_phase_logic.sv =====
// Next-phase and verdict logic for one byte of a number token.
module dnlr_phase_logic (
   input  dnlr_pkg::phase_type   phase_cur,
   input  logic [7:0]            char_code,
   output dnlr_pkg::phase_type   phase_nxt,
   output dnlr_pkg::verdict_type verdict
);

   logic is_dig;
   logic is_sgn;
   logic is_exp;
   logic is_dot;

   // Classify the byte.
   always_comb begin
      is_dig = char_code inside {[dnlr_pkg::CHAR_ZERO:dnlr_pkg::CHAR_NINE]};
      is_sgn = char_code inside {dnlr_pkg::CHAR_PLUS, dnlr_pkg::CHAR_MINUS};
      is_exp = char_code inside {dnlr_pkg::CHAR_EXP_LO, dnlr_pkg::CHAR_EXP_UP};
      is_dot = (char_code == dnlr_pkg::CHAR_DOT);
   end

   // Grammar transitions; any code that names no phase acts as rejected.
   always_comb begin
      phase_nxt = dnlr_pkg::PH_DEAD;
      case (phase_cur)
         dnlr_pkg::PH_START: begin
            if (is_sgn)      phase_nxt = dnlr_pkg::PH_SIGN;
            else if (is_dig) phase_nxt = dnlr_pkg::PH_INT;
            else if (is_dot) phase_nxt = dnlr_pkg::PH_DOT_BARE;
         end
         dnlr_pkg::PH_SIGN: begin
            if (is_dig)      phase_nxt = dnlr_pkg::PH_INT;
            else if (is_dot) phase_nxt = dnlr_pkg::PH_DOT_BARE;
         end
         dnlr_pkg::PH_INT: begin
            if (is_dig)      phase_nxt = dnlr_pkg::PH_INT;
            else if (is_dot) phase_nxt = dnlr_pkg::PH_DOT_INT;
            else if (is_exp) phase_nxt = dnlr_pkg::PH_EXP_MARK;
         end
         dnlr_pkg::PH_DOT_BARE: begin
            if (is_dig)      phase_nxt = dnlr_pkg::PH_FRAC;
         end
         dnlr_pkg::PH_DOT_INT, dnlr_pkg::PH_FRAC: begin
            if (is_dig)      phase_nxt = dnlr_pkg::PH_FRAC;
            else if (is_exp) phase_nxt = dnlr_pkg::PH_EXP_MARK;
         end
         dnlr_pkg::PH_EXP_MARK: begin
            if (is_sgn)      phase_nxt = dnlr_pkg::PH_EXP_SIGN;
            else if (is_dig) phase_nxt = dnlr_pkg::PH_EXP_DIG;
         end
         dnlr_pkg::PH_EXP_SIGN, dnlr_pkg::PH_EXP_DIG: begin
            if (is_dig)      phase_nxt = dnlr_pkg::PH_EXP_DIG;
         end
         default: begin
            phase_nxt = dnlr_pkg::PH_DEAD;
         end
      endcase
   end

   // A prefix is a number when it ends on a digit-bearing phase or a trailing dot.
   always_comb begin
      verdict.is_number = (phase_nxt == dnlr_pkg::PH_INT)     ||
                          (phase_nxt == dnlr_pkg::PH_DOT_INT) ||
                          (phase_nxt == dnlr_pkg::PH_FRAC)    ||
                          (phase_nxt == dnlr_pkg::PH_EXP_DIG);
      verdict.rejected  = (phase_nxt == dnlr_pkg::PH_DEAD);
   end

endmodule

// ===== src/decimal_number_literal_recognizer_top.sv =====
// Top level of the decimal number literal recognizer: input register, phase, output register.
// A word accepted into the input register passes its verdict to the output register and out on rsp_.
// Throughput: one word per cycle unless a stalled result holds the input register; the phase
// update is a single step of a ten-state one-hot machine between the input and output registers.
// The output register is taken while a new word enters, so no bubble is needed.
// Reset (synchronous, active high) empties both registers and returns the phase to start.
`include "decimal_number_literal_recognizer_top_assert.svh"

module decimal_number_literal_recognizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_number,
   output logic       rsp_rejected,
   output logic       rsp_token_end
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [7:0]            s1_char_ff, s1_char_in;
   logic                  s1_last_ff, s1_last_in;
   dnlr_pkg::phase_type   phase_ff, phase_in;
   logic                  out_valid_ff, out_valid_in;
   dnlr_pkg::verdict_type out_verdict_ff, out_verdict_in;
   logic                  out_end_ff, out_end_in;

   dnlr_pkg::phase_type   phase_nxt;
   dnlr_pkg::verdict_type verdict;
   logic                  s1_fire;
   logic                  req_fire;

   // Grammar step for the word held in the input register.
   dnlr_phase_logic u_phase_logic (
      .phase_cur (phase_ff),
      .char_code (s1_char_ff),
      .phase_nxt (phase_nxt),
      .verdict   (verdict)
   );

   // The input register moves on when the output register is empty or being drained.
   assign s1_fire   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // Next values for the input register, phase and output register.
   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_char_in     = s1_char_ff;
      s1_last_in     = s1_last_ff;
      phase_in       = phase_ff;
      out_valid_in   = out_valid_ff;
      out_verdict_in = out_verdict_ff;
      out_end_in     = out_end_ff;

      if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_char_in  = req_char_code;
         s1_last_in  = req_last_char;
      end

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_fire) begin
         out_valid_in   = 1'b1;
         out_verdict_in = verdict;
         out_end_in     = s1_last_ff;
         phase_in       = s1_last_ff ? dnlr_pkg::PH_START : phase_nxt;
      end
   end

   // Control state is reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= dnlr_pkg::PH_START;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
      s1_char_ff     <= s1_char_in;
      s1_last_ff     <= s1_last_in;
      out_verdict_ff <= out_verdict_in;
      out_end_ff     <= out_end_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_is_number = out_verdict_ff.is_number;
   assign rsp_rejected  = out_verdict_ff.rejected;
   assign rsp_token_end = out_end_ff;

   // A verdict cannot be both a number and rejected.
   `DNLR_ASSERT_NOW(a_verdict_excl, clock, reset, rsp_valid, !(rsp_is_number && rsp_rejected))
   // A stalled result blocks the input register from moving on.
   `DNLR_ASSERT_NOW(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, !s1_fire)
   // The last word of a token sends the phase back to start.
   `DNLR_ASSERT_NEXT(a_token_restart, clock, reset, s1_fire && s1_last_ff,
      phase_ff == dnlr_pkg::PH_START)
   // The phase register always holds exactly one phase.
   `DNLR_ASSERT_ALWAYS(a_phase_onehot, clock, reset, $onehot(phase_ff))

endmodule

// ===== test/tb_decimal_number_literal_recognizer_top.sv =====
// Testbench for the decimal number literal recognizer: directed and random tokens checked against a phase model.
`timescale 1ns / 1ps

module tb_decimal_number_literal_recognizer_top;

   // Cycles without any accepted word or result before the run is declared hung.
   localparam int HANG_LIMIT = 1000;
   // Length of the one long receiver hold-off, and the result count that starts it.
   localparam int HOLD_CYCLES = 250;
   localparam int HOLD_AT = 300;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_word_type;

   typedef struct packed {
      logic is_number;
      logic rejected;
      logic token_end;
   } verdict_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code = 8'h00;
   logic       req_last_char = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_is_number;
   logic       rsp_rejected;
   logic       rsp_token_end;

   char_word_type       pending_chars[$];
   verdict_word_type    verdicts_due[$];
   logic [7:0]          token_buf[$];
   dnlr_pkg::phase_type token_phase = dnlr_pkg::PH_START;

   int tx_idle_pct = 18;
   int rx_idle_pct = 71;
   int fail_count = 0;
   int chars_queued = 0;
   int rsp_taken = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   decimal_number_literal_recognizer_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_number (rsp_is_number),
      .rsp_rejected  (rsp_rejected),
      .rsp_token_end (rsp_token_end)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One step of the number grammar for a single byte.
   function automatic dnlr_pkg::phase_type step_phase(input dnlr_pkg::phase_type ph,
                                                      input logic [7:0] c);
      logic dig;
      logic sgn;
      logic ex;
      logic dot;
      dig = (c >= dnlr_pkg::CHAR_ZERO) && (c <= dnlr_pkg::CHAR_NINE);
      sgn = (c == dnlr_pkg::CHAR_PLUS) || (c == dnlr_pkg::CHAR_MINUS);
      ex  = (c == dnlr_pkg::CHAR_EXP_LO) || (c == dnlr_pkg::CHAR_EXP_UP);
      dot = (c == dnlr_pkg::CHAR_DOT);
      case (ph)
         dnlr_pkg::PH_START: begin
            if (sgn) return dnlr_pkg::PH_SIGN;
            if (dig) return dnlr_pkg::PH_INT;
            if (dot) return dnlr_pkg::PH_DOT_BARE;
            return dnlr_pkg::PH_DEAD;
         end
         dnlr_pkg::PH_SIGN: begin
            if (dig) return dnlr_pkg::PH_INT;
            if (dot) return dnlr_pkg::PH_DOT_BARE;
            return dnlr_pkg::PH_DEAD;
         end
         dnlr_pkg::PH_INT: begin
            if (dig) return dnlr_pkg::PH_INT;
            if (dot) return dnlr_pkg::PH_DOT_INT;
            if (ex) return dnlr_pkg::PH_EXP_MARK;
            return dnlr_pkg::PH_DEAD;
         end
         dnlr_pkg::PH_DOT_BARE: begin
            if (dig) return dnlr_pkg::PH_FRAC;
            return dnlr_pkg::PH_DEAD;
         end
         dnlr_pkg::PH_DOT_INT, dnlr_pkg::PH_FRAC: begin
            if (dig) return dnlr_pkg::PH_FRAC;
            if (ex) return dnlr_pkg::PH_EXP_MARK;
            return dnlr_pkg::PH_DEAD;
         end
         dnlr_pkg::PH_EXP_MARK: begin
            if (sgn) return dnlr_pkg::PH_EXP_SIGN;
            if (dig) return dnlr_pkg::PH_EXP_DIG;
            return dnlr_pkg::PH_DEAD;
         end
         dnlr_pkg::PH_EXP_SIGN, dnlr_pkg::PH_EXP_DIG: begin
            if (dig) return dnlr_pkg::PH_EXP_DIG;
            return dnlr_pkg::PH_DEAD;
         end
         default: return dnlr_pkg::PH_DEAD;
      endcase
   endfunction

   // Advance the token phase for an accepted word and queue its expected verdict.
   task automatic predict_verdict(input logic [7:0] c, input logic last);
      dnlr_pkg::phase_type ph;
      verdict_word_type    v;
      ph = step_phase(token_phase, c);
      v.is_number = (ph == dnlr_pkg::PH_INT) || (ph == dnlr_pkg::PH_DOT_INT) ||
                    (ph == dnlr_pkg::PH_FRAC) || (ph == dnlr_pkg::PH_EXP_DIG);
      v.rejected  = (ph == dnlr_pkg::PH_DEAD);
      v.token_end = last;
      verdicts_due.push_back(v);
      token_phase = last ? dnlr_pkg::PH_START : ph;
   endtask

   // Move the token buffer into the pending queue, flagging its final byte.
   task automatic push_token();
      char_word_type w;
      for (int i = 0; i < token_buf.size(); i++) begin
         w.code = token_buf[i];
         w.last = (i == token_buf.size() - 1);
         pending_chars.push_back(w);
      end
      chars_queued += token_buf.size();
   endtask

   task automatic push_text(input string s);
      token_buf.delete();
      for (int i = 0; i < s.len(); i++) token_buf.push_back(s[i]);
      push_token();
   endtask

   function automatic logic [7:0] random_digit();
      return dnlr_pkg::CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] random_sign();
      return $urandom_range(1) ? dnlr_pkg::CHAR_PLUS : dnlr_pkg::CHAR_MINUS;
   endfunction

   // Build a random token: mostly well-formed numbers, some damaged, some pure noise.
   task automatic make_random_token();
      int n_int;
      int n_frac;
      int n_exp;
      int pos;
      bit has_dot;
      logic [7:0] junk;
      token_buf.delete();
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 6)) token_buf.push_back(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(3) == 0) token_buf.push_back(random_sign());
      n_int = $urandom_range(0, 4);
      has_dot = 1'($urandom_range(1));
      n_frac = has_dot ? $urandom_range(0, 3) : 0;
      if (n_int == 0 && n_frac == 0) begin
         if (has_dot) n_frac = 1;
         else n_int = 1;
      end
      repeat (n_int) token_buf.push_back(random_digit());
      if (has_dot) token_buf.push_back(dnlr_pkg::CHAR_DOT);
      repeat (n_frac) token_buf.push_back(random_digit());
      if ($urandom_range(99) < 40) begin
         token_buf.push_back($urandom_range(1) ? dnlr_pkg::CHAR_EXP_LO : dnlr_pkg::CHAR_EXP_UP);
         if ($urandom_range(1)) token_buf.push_back(random_sign());
         n_exp = $urandom_range(0, 3);
         repeat (n_exp) token_buf.push_back(random_digit());
      end
      // Damage a quarter of the tokens with a stray or misplaced byte.
      if ($urandom_range(99) < 25) begin
         case ($urandom_range(4))
            0: junk = dnlr_pkg::CHAR_DOT;
            1: junk = $urandom_range(1) ? dnlr_pkg::CHAR_EXP_LO : dnlr_pkg::CHAR_EXP_UP;
            2: junk = random_sign();
            3: junk = random_digit();
            default: junk = 8'($urandom_range(255));
         endcase
         pos = $urandom_range(token_buf.size() - 1);
         if ($urandom_range(1)) token_buf[pos] = junk;
         else token_buf.insert(pos, junk);
      end
   endtask

   // Sender: offers the next pending word, idling at random between words.
   always @(posedge clock) begin
      char_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_verdict(req_char_code, req_last_char);
         if (!req_valid || req_ready) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               w = pending_chars.pop_front();
               req_valid     <= 1'b1;
               req_char_code <= w.code;
               req_last_char <= w.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random ready, plus one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_taken++;
         if (!hold_done && rsp_taken == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Monitor: every accepted result must match the oldest expected verdict.
   always @(posedge clock) begin
      verdict_word_type got;
      verdict_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_is_number, rsp_rejected, rsp_token_end};
         if (verdicts_due.size() == 0) begin
            $display("%0t: result with none expected: is_number=%b rejected=%b token_end=%b",
                     $time, got.is_number, got.rejected, got.token_end);
            fail_count++;
         end else begin
            want = verdicts_due.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected is_number=%b rejected=%b token_end=%b, %s%b %s%b %s%b",
                        $time, want.is_number, want.rejected, want.token_end,
                        "actual is_number=", got.is_number, "rejected=", got.rejected,
                        "token_end=", got.token_end);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_chars.size() != 0 || req_valid || verdicts_due.size() != 0)
         @(negedge clock);
   endtask

   // Stimulus: directed tokens, then three random phases with different idling.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Every live phase of the grammar, trailing dot with exponent, bare dots.
      push_text("+1.e5");
      push_text(".5E+9");
      push_text(".");
      push_text("-.");
      // Bytes outside the grammar, then a rejected token stays rejected.
      token_buf.delete();
      token_buf.push_back(8'hFF);
      token_buf.push_back(dnlr_pkg::CHAR_NINE);
      push_token();
      token_buf.delete();
      token_buf.push_back(8'h00);
      push_token();
      // Repeated dot and repeated exponent letter.
      push_text("1..");
      push_text("1e5e");
      push_text("0");
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 71 : 0;
         rx_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 18 : 0;
         while (chars_queued < 24 + 520 * (ph + 1)) begin
            make_random_token();
            push_token();
         end
         wait_drained();
      end

      repeat (6) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
